### sv/falru_pkg.sv
`default_nettype none

package falru_pkg;

  localparam int NUM_LINES       = 64;
  localparam int LINE_SIZE_BYTES = 64;
  localparam int ADDRESS_BITS    = 32;

  localparam int ADDR_W     = 32;
  localparam int MISS_W     = 32;
  localparam int EFF_ADDR_W = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int OFFSET_W   = $clog2(LINE_SIZE_BYTES);
  localparam int TAG_W      = EFF_ADDR_W - OFFSET_W;
  localparam int IDX_W      = $clog2(NUM_LINES);
  localparam int RANK_W     = IDX_W;
  localparam int LIMIT_W    = RANK_W + 1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [MISS_W-1:0]  miss_t;

  localparam rank_t  RANK_LAST  = rank_t'(NUM_LINES - 1);
  localparam limit_t LIMIT_FREE = limit_t'(NUM_LINES);
  localparam miss_t  MISS_MAX   = {MISS_W{1'b1}};

  // Outcome of one lookup: the slot that becomes most recent, and the rank
  // below which every other valid line ages by one step.
  typedef struct packed {
    logic   hit;
    idx_t   slot;
    limit_t limit;
  } lkp_t;

endpackage

`default_nettype wire

### sv/falru_lookup.sv
`default_nettype none

module falru_lookup (
  input  wire falru_pkg::tag_t                       line_i,
  input  wire falru_pkg::tag_t                       tag_i   [falru_pkg::NUM_LINES],
  input  wire logic [falru_pkg::NUM_LINES-1:0]       valid_i,
  input  wire falru_pkg::rank_t                      rank_i  [falru_pkg::NUM_LINES],
  output falru_pkg::lkp_t                            lkp_o
);
  import falru_pkg::*;

  logic  hit_found;
  idx_t  hit_idx;
  rank_t hit_rank;
  logic  free_found;
  idx_t  free_idx;
  idx_t  victim_idx;

  // Lowest index wins for both the matching line and the free slot.
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    hit_rank   = '0;
    free_found = 1'b0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (valid_i[i] && tag_i[i] == line_i) begin
        hit_found = 1'b1;
        hit_idx   = idx_t'(i);
        hit_rank  = rank_i[i];
      end
      if (!valid_i[i]) begin
        free_found = 1'b1;
        free_idx   = idx_t'(i);
      end
      if (valid_i[i] && rank_i[i] == RANK_LAST) begin
        victim_idx = idx_t'(i);
      end
    end
  end

  always_comb begin
    lkp_o.hit = hit_found;
    if (hit_found) begin
      lkp_o.slot  = hit_idx;
      lkp_o.limit = {1'b0, hit_rank};
    end else if (free_found) begin
      lkp_o.slot  = free_idx;
      lkp_o.limit = LIMIT_FREE;
    end else begin
      lkp_o.slot  = victim_idx;
      lkp_o.limit = {1'b0, RANK_LAST};
    end
  end

endmodule

`default_nettype wire

### sv/falru_lines.sv
`default_nettype none

module falru_lines (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  upd_en_i,
  input  wire falru_pkg::tag_t                       line_i,
  input  wire falru_pkg::lkp_t                       lkp_i,
  output falru_pkg::tag_t                            tag_o   [falru_pkg::NUM_LINES],
  output logic [falru_pkg::NUM_LINES-1:0]            valid_o,
  output falru_pkg::rank_t                           rank_o  [falru_pkg::NUM_LINES]
);
  import falru_pkg::*;

  tag_t                 tag_r  [NUM_LINES];
  logic [NUM_LINES-1:0] valid_r;
  rank_t                rank_r [NUM_LINES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (upd_en_i) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (idx_t'(i) == lkp_i.slot) begin
          valid_r[i] <= 1'b1;
          rank_r[i]  <= '0;
        end else if (valid_r[i] && {1'b0, rank_r[i]} < lkp_i.limit) begin
          rank_r[i] <= rank_t'(rank_r[i] + rank_t'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en_i && !lkp_i.hit) begin
      tag_r[lkp_i.slot] <= line_i;
    end
  end

  assign tag_o   = tag_r;
  assign valid_o = valid_r;
  assign rank_o  = rank_r;

  a_slot_most_recent: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en_i |=> valid_r[$past(lkp_i.slot)] && rank_r[$past(lkp_i.slot)] == '0)
    else $error("updated slot is not valid and most recent");

  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(valid_r) >= $past($countones(valid_r)))
    else $error("a resident line was dropped");

  a_miss_fills: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en_i && !lkp_i.hit && !(&valid_r) |=>
      $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("miss with a free slot did not fill it");

endmodule

`default_nettype wire

### sv/fully_assoc_lru_miss_counter.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         start, busy            in_byte_address
// result    out        out_valid (strobe)     out_hit, out_miss_total
//
// A request is taken on every clock edge with start high; busy stays low.
// Its result appears for one cycle, after the input register and one lookup stage
// that compares all line tags in parallel and updates the recency ranks, from the output register.
// Throughput is one request per cycle.
// Synchronous reset empties the cache and clears the miss count at once.
// The receiver cannot stall the result strobe.

module fully_assoc_lru_miss_counter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire falru_pkg::addr_t  in_byte_address,
  output logic                   out_valid,
  output logic                   out_hit,
  output falru_pkg::miss_t       out_miss_total
);
  import falru_pkg::*;

  logic                 in_vld_r;
  tag_t                 line_r;
  miss_t                miss_r;
  miss_t                miss_nxt;
  logic                 out_valid_r;
  logic                 out_hit_r;
  miss_t                out_miss_r;
  lkp_t                 lkp;
  tag_t                 tag_w   [NUM_LINES];
  logic [NUM_LINES-1:0] valid_w;
  rank_t                rank_w  [NUM_LINES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      line_r <= in_byte_address[EFF_ADDR_W-1:OFFSET_W];
    end
  end

  falru_lookup u_lookup (
    .line_i  (line_r),
    .tag_i   (tag_w),
    .valid_i (valid_w),
    .rank_i  (rank_w),
    .lkp_o   (lkp)
  );

  falru_lines u_lines (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en_i (in_vld_r),
    .line_i   (line_r),
    .lkp_i    (lkp),
    .tag_o    (tag_w),
    .valid_o  (valid_w),
    .rank_o   (rank_w)
  );

  always_comb begin
    miss_nxt = miss_r;
    if (in_vld_r && !lkp.hit && miss_r != MISS_MAX) begin
      miss_nxt = miss_t'(miss_r + miss_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      miss_r      <= miss_nxt;
      out_valid_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_hit_r  <= lkp.hit;
      out_miss_r <= miss_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_miss_total = out_miss_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("request produced no result");

  a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_miss_total == miss_r)
    else $error("reported miss total differs from the counter");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && lkp.hit |=> miss_r == $past(miss_r))
    else $error("miss counter moved on a hit");

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import falru_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ACCESSES = 800;
  localparam int CALM_TAIL = 100;
  localparam int POOL_SIZE = 128;
  localparam int HISTORY_DEPTH = 8;

  typedef struct packed {
    logic  hit;
    miss_t miss_total;
  } lookup_t;

  class lru_tracker;
    tag_t    line_tags[NUM_LINES];
    bit      line_valid[NUM_LINES];
    rank_t   line_ranks[NUM_LINES];
    miss_t   misses;
    lookup_t expected_lookups[$];
    int      errors;

    function new();
      for (int i = 0; i < NUM_LINES; i++) begin
        line_tags[i] = '0;
        line_valid[i] = 1'b0;
        line_ranks[i] = '0;
      end
      misses = '0;
      errors = 0;
    endfunction

    function void note_access(addr_t byte_address);
      tag_t    line;
      int      found;
      int      free_slot;
      int      victim;
      int      count;
      int      slot;
      int      limit;
      lookup_t lookup;
      line = tag_t'(byte_address >> OFFSET_W);
      found = -1;
      free_slot = -1;
      victim = -1;
      count = 0;
      for (int i = 0; i < NUM_LINES; i++) begin
        if (line_valid[i]) begin
          count++;
          if (line_tags[i] == line && found < 0) found = i;
          if (line_ranks[i] == RANK_LAST) victim = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (found >= 0) begin
        limit = int'(line_ranks[found]);
        for (int i = 0; i < NUM_LINES; i++)
          if (line_valid[i] && int'(line_ranks[i]) < limit) line_ranks[i]++;
        line_ranks[found] = '0;
        lookup.hit = 1'b1;
      end else begin
        if (misses != MISS_MAX) misses++;
        if (count < NUM_LINES && free_slot >= 0) begin
          slot = free_slot;
          limit = NUM_LINES;
        end else begin
          slot = (victim >= 0) ? victim : 0;
          limit = int'(line_ranks[slot]);
        end
        for (int i = 0; i < NUM_LINES; i++)
          if (line_valid[i] && i != slot && int'(line_ranks[i]) < limit) line_ranks[i]++;
        line_tags[slot] = line;
        line_valid[slot] = 1'b1;
        line_ranks[slot] = '0;
        lookup.hit = 1'b0;
      end
      lookup.miss_total = misses;
      expected_lookups.push_back(lookup);
    endfunction

    function void check_result(logic hit, miss_t miss_total);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit %0b miss_total %0d",
                 $time, hit, miss_total);
        errors++;
        return;
      end
      want = expected_lookups.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit, hit);
        errors++;
      end
      if (miss_total !== want.miss_total) begin
        $display("%0t: miss_total mismatch, expected %0d, actual %0d",
                 $time, want.miss_total, miss_total);
        errors++;
      end
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  addr_t in_byte_address;
  logic  out_valid;
  logic  out_hit;
  miss_t out_miss_total;

  lru_tracker tracker = new();
  int         cycle_count = 0;
  tag_t       line_pool[POOL_SIZE];
  tag_t       recent_lines[$];
  int         pool_span;
  int         idle_percent;

  fully_assoc_lru_miss_counter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_byte_address (in_byte_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_miss_total  (out_miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_hit, out_miss_total);
  end

  task automatic send_request(input addr_t byte_address);
    start <= 1'b1;
    in_byte_address <= byte_address;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    tracker.note_access(byte_address);
    recent_lines.push_back(tag_t'(byte_address >> OFFSET_W));
    if (recent_lines.size() > HISTORY_DEPTH) void'(recent_lines.pop_front());
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  function automatic addr_t line_address(tag_t line);
    return (addr_t'(line) << OFFSET_W) | addr_t'($urandom_range(0, LINE_SIZE_BYTES - 1));
  endfunction

  function automatic void refill_pool();
    tag_t base;
    bit   clustered;
    base = tag_t'($urandom);
    clustered = 1'($urandom_range(0, 1));
    for (int i = 0; i < POOL_SIZE; i++)
      line_pool[i] = clustered ? base + tag_t'(i) : tag_t'($urandom);
  endfunction

  function automatic addr_t random_address();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return addr_t'($urandom);
    if (pick < 35 && recent_lines.size() > 0)
      return line_address(recent_lines[$urandom_range(0, recent_lines.size() - 1)]);
    return line_address(line_pool[$urandom_range(0, pool_span - 1)]);
  endfunction

  initial begin
    int spans[6];
    spans = '{32, 63, 64, 65, 80, POOL_SIZE};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_byte_address <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'h0000_003F);
    send_request(32'h0000_0040);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFC0);
    send_request(32'h8000_0000);
    send_request(32'h7FFF_FFFF);
    send_request(32'h5555_5555);
    send_request(32'hAAAA_AAAA);
    send_request(32'h0000_0041);
    send_request(32'h0000_0000);
    idle_burst();
    send_request(32'hFFFF_FFFE);

    refill_pool();
    pool_span = POOL_SIZE;
    idle_percent = 20;
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if (n % 100 == 0) begin
        if ($urandom_range(0, 2) == 0) refill_pool();
        pool_span = spans[$urandom_range(0, 5)];
        idle_percent = (n % 300 == 0) ? 0 : $urandom_range(10, 50);
      end
      if (n < RANDOM_ACCESSES - CALM_TAIL && $urandom_range(0, 99) < idle_percent)
        idle_burst();
      send_request(random_address());
    end
    start <= 1'b0;

    while (tracker.expected_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/falru_pkg.sv
sv/falru_lookup.sv
sv/falru_lines.sv
sv/fully_assoc_lru_miss_counter.sv
test/testbench.sv
